// ===== rtl/core/hsg_pkg.sv =====
// ----------------------------------------------------------------------------
// hsg_pkg: shared types and constants of the Halton sample generator
// Widths, command codes, prime and reciprocal tables, the microcode word
// layout and the status fed back from the datapath to the sequencer.
// ----------------------------------------------------------------------------
package hsg_pkg;

  // Default parameter values
  localparam int INDEX_BITS_DEF = 20;
  localparam int DIMENSIONS_DEF = 16;

  // Fixed field widths
  localparam int FRAC_W    = 32;   // Q0.32 fraction, shift and value
  localparam int DIM_OUT_W = 4;    // dimension field of a result
  localparam int BASE_W    = 8;    // largest prime (131) fits here
  localparam int TABLE_W   = 5;    // prime table index
  localparam int CNT_W     = $clog2(FRAC_W);

  // Command codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // Microcode step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_INIT = 3'd0;  // load digit loop, fetch base
  localparam step_t STEP_QUO  = 3'd1;  // first quotient, skip on zero index
  localparam step_t STEP_REM  = 3'd2;  // digit and new index
  localparam step_t STEP_ACC  = 3'd3;  // fold digit, next quotient
  localparam step_t STEP_DIV  = 3'd4;  // one quotient bit of R * 2^32 / b^k
  localparam step_t STEP_OUT  = 3'd5;  // add shift, emit beat

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NONE      = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_N_ZERO    = 3'd2,
    COND_N_NONZERO = 3'd3,
    COND_DIV_BUSY  = 3'd4
  } cond_t;

  // One control word
  typedef struct packed {
    logic  load_n;   // load index, base, reciprocal; clear R, set b^k = 1
    logic  do_quo;   // quotient by reciprocal multiply
    logic  do_rem;   // remainder, advance index to quotient
    logic  do_acc;   // R = R*b + digit, b^k = b^k * b
    logic  do_div;   // one restoring division step
    logic  do_out;   // result register load, dimension advance
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_t;

  // Datapath flags for the sequencer
  typedef struct packed {
    logic n_zero;
    logic div_last;
    logic out_free;
  } status_t;

  // Successive primes
  function automatic logic [BASE_W-1:0] prime_base(input logic [TABLE_W-1:0] idx);
    logic [BASE_W-1:0] b;
    case (idx)
      5'd0:  b = 8'd2;    5'd1:  b = 8'd3;    5'd2:  b = 8'd5;    5'd3:  b = 8'd7;
      5'd4:  b = 8'd11;   5'd5:  b = 8'd13;   5'd6:  b = 8'd17;   5'd7:  b = 8'd19;
      5'd8:  b = 8'd23;   5'd9:  b = 8'd29;   5'd10: b = 8'd31;   5'd11: b = 8'd37;
      5'd12: b = 8'd41;   5'd13: b = 8'd43;   5'd14: b = 8'd47;   5'd15: b = 8'd53;
      5'd16: b = 8'd59;   5'd17: b = 8'd61;   5'd18: b = 8'd67;   5'd19: b = 8'd71;
      5'd20: b = 8'd73;   5'd21: b = 8'd79;   5'd22: b = 8'd83;   5'd23: b = 8'd89;
      5'd24: b = 8'd97;   5'd25: b = 8'd101;  5'd26: b = 8'd103;  5'd27: b = 8'd107;
      5'd28: b = 8'd109;  5'd29: b = 8'd113;  5'd30: b = 8'd127;  default: b = 8'd131;
    endcase
    return b;
  endfunction

  // ceil(2^32 / prime): exact quotient for any index below 2^24
  function automatic logic [FRAC_W-1:0] prime_recip(input logic [TABLE_W-1:0] idx);
    logic [FRAC_W-1:0] m;
    case (idx)
      5'd0:  m = 32'd2147483648;  5'd1:  m = 32'd1431655766;
      5'd2:  m = 32'd858993460;   5'd3:  m = 32'd613566757;
      5'd4:  m = 32'd390451573;   5'd5:  m = 32'd330382100;
      5'd6:  m = 32'd252645136;   5'd7:  m = 32'd226050911;
      5'd8:  m = 32'd186737709;   5'd9:  m = 32'd148102321;
      5'd10: m = 32'd138547333;   5'd11: m = 32'd116080198;
      5'd12: m = 32'd104755300;   5'd13: m = 32'd99882961;
      5'd14: m = 32'd91382283;    5'd15: m = 32'd81037119;
      5'd16: m = 32'd72796056;    5'd17: m = 32'd70409300;
      5'd18: m = 32'd64103990;    5'd19: m = 32'd60492498;
      5'd20: m = 32'd58835169;    5'd21: m = 32'd54366675;
      5'd22: m = 32'd51746594;    5'd23: m = 32'd48258060;
      5'd24: m = 32'd44278014;    5'd25: m = 32'd42524429;
      5'd26: m = 32'd41698712;    5'd27: m = 32'd40139882;
      5'd28: m = 32'd39403370;    5'd29: m = 32'd38008561;
      5'd30: m = 32'd33818641;    default: m = 32'd32786010;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/hsg_if.sv =====
// ----------------------------------------------------------------------------
// hsg_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hsg_cmd_if #(
  parameter int INDEX_BITS = hsg_pkg::INDEX_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [INDEX_BITS-1:0]         index_in;
  logic [hsg_pkg::FRAC_W-1:0]    shift_in;

  modport source (output valid, output operation, output index_in, output shift_in,
                  input ready);
  modport sink   (input valid, input operation, input index_in, input shift_in,
                  output ready);
endinterface

interface hsg_res_if;
  logic                           valid;
  logic                           ready;
  logic [hsg_pkg::FRAC_W-1:0]     value;
  logic [hsg_pkg::DIM_OUT_W-1:0]  dimension;
  logic                           exhausted;

  modport source (output valid, output value, output dimension, output exhausted,
                  input ready);
  modport sink   (input valid, input value, input dimension, input exhausted,
                  output ready);
endinterface

// ===== rtl/core/hsg_sequencer.sv =====
// ----------------------------------------------------------------------------
// hsg_sequencer: microcode step counter and control store
// Walks the per-dimension program, takes conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module hsg_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  hsg_pkg::status_t status,
  output hsg_pkg::ctrl_t   ctrl,
  output logic             busy
);

  function automatic hsg_pkg::ctrl_t ucode(input hsg_pkg::step_t pc);
    hsg_pkg::ctrl_t w;
    w        = '0;
    w.cond   = hsg_pkg::COND_NONE;
    w.target = hsg_pkg::STEP_INIT;
    unique case (pc)
      hsg_pkg::STEP_INIT: begin
        w.load_n = 1'b1;
      end
      hsg_pkg::STEP_QUO: begin
        w.do_quo = 1'b1;
        w.cond   = hsg_pkg::COND_N_ZERO;
        w.target = hsg_pkg::STEP_DIV;
      end
      hsg_pkg::STEP_REM: begin
        w.do_rem = 1'b1;
      end
      hsg_pkg::STEP_ACC: begin
        w.do_acc = 1'b1;
        w.do_quo = 1'b1;
        w.cond   = hsg_pkg::COND_N_NONZERO;
        w.target = hsg_pkg::STEP_REM;
      end
      hsg_pkg::STEP_DIV: begin
        w.do_div = 1'b1;
        w.cond   = hsg_pkg::COND_DIV_BUSY;
        w.target = hsg_pkg::STEP_DIV;
      end
      hsg_pkg::STEP_OUT: begin
        w.do_out = 1'b1;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  hsg_pkg::step_t pc;
  hsg_pkg::ctrl_t word;
  logic           stall;
  logic           taken;

  assign word  = ucode(pc);
  // hold at the emit step while the result register is still full
  assign stall = word.do_out && !status.out_free;
  assign ctrl  = (busy && !stall) ? word : '0;

  always_comb begin
    unique case (word.cond)
      hsg_pkg::COND_NONE:      taken = 1'b0;
      hsg_pkg::COND_ALWAYS:    taken = 1'b1;
      hsg_pkg::COND_N_ZERO:    taken = status.n_zero;
      hsg_pkg::COND_N_NONZERO: taken = !status.n_zero;
      hsg_pkg::COND_DIV_BUSY:  taken = !status.div_last;
      default:                 taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= hsg_pkg::STEP_INIT;
    end else if (go) begin
      busy <= 1'b1;
      pc   <= hsg_pkg::STEP_INIT;
    end else if (busy && !stall) begin
      if (word.last) begin
        busy <= 1'b0;
      end
      pc <= taken ? word.target : pc + 3'd1;
    end
  end

endmodule

// ===== rtl/core/hsg_datapath.sv =====
// ----------------------------------------------------------------------------
// hsg_datapath: digit loop, long division and result register
// Sample state, reciprocal-multiply digit extraction, restoring divider.
// ----------------------------------------------------------------------------
module hsg_datapath #(
  parameter int INDEX_BITS = hsg_pkg::INDEX_BITS_DEF,
  parameter int DIMENSIONS = hsg_pkg::DIMENSIONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hsg_pkg::ctrl_t                   ctrl,
  input  logic                             load,
  input  logic [INDEX_BITS-1:0]            index_in,
  input  logic [hsg_pkg::FRAC_W-1:0]       shift_in,
  input  logic                             res_ready,
  output hsg_pkg::status_t                 status,
  output logic                             res_valid,
  output logic [hsg_pkg::FRAC_W-1:0]       value,
  output logic [hsg_pkg::DIM_OUT_W-1:0]    dimension,
  output logic                             exhausted
);

  localparam int DIM_W = $clog2(DIMENSIONS);
  localparam int FW    = hsg_pkg::FRAC_W;
  localparam int BW    = hsg_pkg::BASE_W;

  // sample state
  logic [INDEX_BITS-1:0] index;
  logic [FW-1:0]         shift;
  logic [DIM_W-1:0]      dim_count;
  logic                  past_end;

  // digit loop and divider
  logic [INDEX_BITS-1:0] n;
  logic [INDEX_BITS-1:0] q;
  logic [BW-1:0]         digit;
  logic [BW-1:0]         base;
  logic [FW-1:0]         recip;
  logic [FW-1:0]         rev;
  logic [FW-1:0]         scale;
  logic [FW-1:0]         frac;
  logic [hsg_pkg::CNT_W-1:0] div_cnt;

  logic [INDEX_BITS+FW-1:0] quo_prod;
  logic [INDEX_BITS+BW-1:0] rem_prod;
  logic [INDEX_BITS+BW-1:0] rem_diff;
  logic [FW+BW-1:0]         rev_prod;
  logic [FW+BW-1:0]         scale_prod;
  logic [FW:0]              dbl;
  logic                     fits;
  logic [FW:0]              dbl_diff;
  logic                     dim_at_end;

  assign quo_prod   = {{FW{1'b0}}, n} * {{INDEX_BITS{1'b0}}, recip};
  assign rem_prod   = {{BW{1'b0}}, q} * {{INDEX_BITS{1'b0}}, base};
  assign rem_diff   = {{BW{1'b0}}, n} - rem_prod;
  assign rev_prod   = {{BW{1'b0}}, rev} * {{FW{1'b0}}, base} + {{FW{1'b0}}, digit};
  assign scale_prod = {{BW{1'b0}}, scale} * {{FW{1'b0}}, base};
  assign dbl        = {rev, 1'b0};
  assign dbl_diff   = dbl - {1'b0, scale};
  assign fits       = dbl >= {1'b0, scale};
  assign dim_at_end = dim_count == DIM_W'(DIMENSIONS - 1);

  assign status.n_zero   = n == '0;
  assign status.div_last = div_cnt == hsg_pkg::CNT_W'(FW - 1);
  assign status.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (ctrl.load_n) begin
      n     <= index;
      base  <= hsg_pkg::prime_base(hsg_pkg::TABLE_W'(dim_count));
      recip <= hsg_pkg::prime_recip(hsg_pkg::TABLE_W'(dim_count));
      rev   <= '0;
      scale <= FW'(1);
    end else begin
      if (ctrl.do_rem) begin
        digit <= rem_diff[BW-1:0];
        n     <= q;
      end
      if (ctrl.do_acc) begin
        rev   <= rev_prod[FW-1:0];
        scale <= scale_prod[FW-1:0];
      end
      if (ctrl.do_div) begin
        rev  <= fits ? dbl_diff[FW-1:0] : dbl[FW-1:0];
        frac <= {frac[FW-2:0], fits};
      end
    end
    if (ctrl.do_quo) begin
      q <= quo_prod[INDEX_BITS+FW-1:FW];
    end
    if (ctrl.do_out) begin
      value     <= FW'(frac + shift);
      dimension <= hsg_pkg::DIM_OUT_W'(dim_count);
      exhausted <= past_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctrl.do_div) begin
      div_cnt <= div_cnt + 1'b1;
    end else begin
      div_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index     <= '0;
      shift     <= '0;
      dim_count <= '0;
      past_end  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        index     <= index_in;
        shift     <= shift_in;
        dim_count <= '0;
        past_end  <= 1'b0;
      end else if (ctrl.do_out) begin
        if (dim_at_end) begin
          past_end <= 1'b1;
        end else begin
          dim_count <= dim_count + 1'b1;
        end
      end
      if (ctrl.do_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/halton_sample_generator.sv =====
// ----------------------------------------------------------------------------
// halton_sample_generator: shifted Halton radical inverse in Q0.32
// A start beat loads a sample index and a Q0.32 shift; each next beat gives
// the radical inverse of the index in the prime base of the current
// dimension plus the shift modulo 1, then moves on up to the last dimension.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                 beat moves on
//   -------  ---  --------------------------------------  -----------------
//   cmd      in   operation, index_in, shift_in           valid && ready
//   result   out  value, dimension, exhausted             valid && ready
//
// A start beat loads the sample state and gives no result. A next beat runs
// a microcode program: fetch the base, take the first quotient, then a
// remainder step and an accumulate step per base-b digit of the index,
// restoring division for floor(R * 2^32 / b^k) and an emit step; cmd.ready
// rises again once the program ends. The digit loop is a reciprocal
// multiply, then a multiply-subtract; the divider gives one quotient bit
// per cycle.
// Reset clears the sample state to index 0, shift 0, dimension 0.
// A full result register does not block cmd: the next beat is taken and its
// program holds at the emit step until result.ready frees the register.
// ----------------------------------------------------------------------------
module halton_sample_generator #(
  parameter int INDEX_BITS = hsg_pkg::INDEX_BITS_DEF,
  parameter int DIMENSIONS = hsg_pkg::DIMENSIONS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hsg_cmd_if.sink    cmd,
  hsg_res_if.source  result
);

  hsg_pkg::ctrl_t   ctrl;
  hsg_pkg::status_t status;
  logic             busy;
  logic             accept;
  logic             go;
  logic             load;

  // one item at a time: take a command only while no program runs,
  // and never while reset is held
  assign cmd.ready = !busy && !rst;
  assign accept    = cmd.valid && cmd.ready;
  // next: run the program; start: load the sample state directly
  assign go        = accept && (cmd.operation == hsg_pkg::OP_NEXT);
  assign load      = accept && (cmd.operation == hsg_pkg::OP_START);

  hsg_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  hsg_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .DIMENSIONS (DIMENSIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .load      (load),
    .index_in  (cmd.index_in),
    .shift_in  (cmd.shift_in),
    .res_ready (result.ready),
    .status    (status),
    .res_valid (result.valid),
    .value     (result.value),
    .dimension (result.dimension),
    .exhausted (result.exhausted)
  );

endmodule
